FILE: rtl/core/sbe_pkg.sv
package sbe_pkg;

    localparam int PC_W     = 10;
    localparam int METHOD_W = 4;
    localparam int OP_W     = 5;
    localparam int ST_W     = 3;

    localparam logic [OP_W-1:0] OP_LOAD    = 5'd0;
    localparam logic [OP_W-1:0] OP_CONST   = 5'd1;
    localparam logic [OP_W-1:0] OP_STORE   = 5'd2;
    localparam logic [OP_W-1:0] OP_ADD     = 5'd3;
    localparam logic [OP_W-1:0] OP_SUB     = 5'd4;
    localparam logic [OP_W-1:0] OP_MUL     = 5'd5;
    localparam logic [OP_W-1:0] OP_DIV     = 5'd6;
    localparam logic [OP_W-1:0] OP_LT      = 5'd7;
    localparam logic [OP_W-1:0] OP_EQ      = 5'd8;
    localparam logic [OP_W-1:0] OP_AND     = 5'd9;
    localparam logic [OP_W-1:0] OP_OR      = 5'd10;
    localparam logic [OP_W-1:0] OP_NOT     = 5'd11;
    localparam logic [OP_W-1:0] OP_GOTO    = 5'd12;
    localparam logic [OP_W-1:0] OP_IFFALSE = 5'd13;
    localparam logic [OP_W-1:0] OP_CALL    = 5'd14;
    localparam logic [OP_W-1:0] OP_RETURN  = 5'd15;
    localparam logic [OP_W-1:0] OP_PRINT   = 5'd16;
    localparam logic [OP_W-1:0] OP_STOP    = 5'd17;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW  = 3'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW   = 3'd2;
    localparam logic [ST_W-1:0] ST_DIV_ZERO   = 3'd3;
    localparam logic [ST_W-1:0] ST_FRAME_OVF  = 3'd4;
    localparam logic [ST_W-1:0] ST_NO_CALLER  = 3'd5;

    localparam logic [METHOD_W-1:0] MAIN_METHOD = 4'd0;

    typedef struct packed {
        logic [OP_W-1:0]     action;
        logic signed [31:0]  immediate;
        logic [3:0]          var_index;
        logic [PC_W-1:0]     jump_target;
        logic [METHOD_W-1:0] method_target;
    } t_in_item;

    typedef struct packed {
        logic [PC_W-1:0]     next_pc;
        logic [METHOD_W-1:0] method_id;
        logic                print_valid;
        logic signed [31:0]  print_value;
        logic                halted;
        logic [ST_W-1:0]     status;
    } t_out_item;

    typedef struct packed {
        logic load_instr;
        logic cap_b;
        logic cap_a;
        logic div_start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic go_div;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/core/sbe_ram.sv
module sbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/sbe_div.sv
module sbe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_step;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;
    logic        r_neg;
    logic [32:0] s_shift;
    logic [32:0] s_diff;

    assign s_shift = {r_rem, r_quo[31]};
    assign s_diff  = s_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division on magnitudes, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_den <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            if (!s_diff[32]) begin
                r_rem <= s_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= s_shift[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

FILE: rtl/core/sbe_ctrl.sv
module sbe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  sbe_pkg::t_stat i_stat,
    output logic          o_in_stall,
    output sbe_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDB  = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_instr = 1'b1;
                    n_state = S_RDB;
                end
            end
            S_RDB: begin
                o_cmd.cap_b = 1'b1;
                n_state = S_RDA;
            end
            S_RDA: begin
                o_cmd.cap_a = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.go_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/core/sbe_dpath.sv
module sbe_dpath #(
    parameter int STACK_DEPTH = 256,
    parameter int FRAME_DEPTH = 16,
    parameter int LOCALS      = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbe_pkg::t_in_item   i_in_item,
    input  sbe_pkg::t_cmd       i_cmd,
    output sbe_pkg::t_stat      o_stat,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output sbe_pkg::t_out_item  o_out_item
);

    localparam int SAW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW     = $clog2(STACK_DEPTH + 1);
    localparam int FAW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FCW    = $clog2(FRAME_DEPTH + 1);
    localparam int NSLOTS = (FRAME_DEPTH + 1) * LOCALS;
    localparam int LAW    = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int VW     = (LOCALS > 1) ? $clog2(LOCALS) : 1;
    localparam int RETW   = sbe_pkg::PC_W + sbe_pkg::METHOD_W;

    sbe_pkg::t_in_item  r_ins;
    sbe_pkg::t_out_item r_out;
    sbe_pkg::t_out_item n_out;
    logic [31:0]                   r_a;
    logic [31:0]                   r_b;
    logic [31:0]                   r_lv;
    logic [sbe_pkg::PC_W-1:0]      r_rpc;
    logic [sbe_pkg::METHOD_W-1:0]  r_rm;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 n_cnt;
    logic [FCW-1:0]                r_frame;
    logic [FCW-1:0]                n_frame;
    logic [sbe_pkg::PC_W-1:0]      r_pc;
    logic [sbe_pkg::PC_W-1:0]      n_pc;
    logic [sbe_pkg::METHOD_W-1:0]  r_method;
    logic [sbe_pkg::METHOD_W-1:0]  n_method;
    logic                          r_halt;
    logic                          n_halt;
    logic                          r_oval;
    logic [LOCALS-1:0]             r_lw [FRAME_DEPTH+1];

    logic [VW-1:0]                 s_vi_tab [16];
    logic [VW-1:0]                 s_vi;
    logic [LAW-1:0]                s_slot;
    logic [FCW-1:0]                s_frame_inc;
    logic [sbe_pkg::PC_W-1:0]      s_pc_inc;
    logic [sbe_pkg::OP_W-1:0]      s_op;
    logic [1:0]                    s_need;
    logic                          s_push;
    logic [sbe_pkg::ST_W-1:0]      s_st;
    logic                          s_ok;
    logic [31:0]                   s_res;
    logic                          s_pv;
    logic [31:0]                   s_pval;
    logic [31:0]                   s_stack_rd;
    logic [31:0]                   s_local_rd;
    logic [RETW-1:0]               s_ret_rd;
    logic [31:0]                   s_quo;
    logic                          s_div_done;

    genvar g;
    generate
        for (g = 0; g < 16; g++) begin : g_vi
            assign s_vi_tab[g] = VW'(g % LOCALS);
        end
    endgenerate

    assign s_op        = r_ins.action;
    assign s_vi        = s_vi_tab[r_ins.var_index];
    assign s_slot      = LAW'(r_frame) * LAW'(LOCALS) + LAW'(s_vi);
    assign s_frame_inc = r_frame + FCW'(1);
    assign s_pc_inc    = r_pc + sbe_pkg::PC_W'(1);

    always_comb begin
        unique case (s_op) inside
            [sbe_pkg::OP_ADD:sbe_pkg::OP_OR]: s_need = 2'd2;
            sbe_pkg::OP_STORE, sbe_pkg::OP_NOT,
            sbe_pkg::OP_IFFALSE, sbe_pkg::OP_PRINT: s_need = 2'd1;
            default: s_need = 2'd0;
        endcase
    end

    // error priority: underflow, overflow, then the rest
    always_comb begin
        s_st = sbe_pkg::ST_OK;
        if (r_cnt < CW'(s_need)) begin
            s_st = sbe_pkg::ST_UNDERFLOW;
        end else if ((s_op == sbe_pkg::OP_LOAD || s_op == sbe_pkg::OP_CONST)
                     && r_cnt >= CW'(STACK_DEPTH)) begin
            s_st = sbe_pkg::ST_OVERFLOW;
        end else if (s_op == sbe_pkg::OP_DIV && r_b == 32'd0) begin
            s_st = sbe_pkg::ST_DIV_ZERO;
        end else if (s_op == sbe_pkg::OP_CALL && r_frame >= FCW'(FRAME_DEPTH)) begin
            s_st = sbe_pkg::ST_FRAME_OVF;
        end else if (s_op == sbe_pkg::OP_RETURN && r_frame == '0) begin
            s_st = sbe_pkg::ST_NO_CALLER;
        end
    end

    assign s_ok = !r_halt && (s_st == sbe_pkg::ST_OK);

    always_comb begin
        s_res  = '0;
        s_push = 1'b1;
        unique case (s_op)
            sbe_pkg::OP_LOAD:  s_res = r_lw[r_frame][s_vi] ? r_lv : 32'd0;
            sbe_pkg::OP_CONST: s_res = r_ins.immediate;
            sbe_pkg::OP_ADD:   s_res = r_a + r_b;
            sbe_pkg::OP_SUB:   s_res = r_a - r_b;
            sbe_pkg::OP_MUL:   s_res = r_a * r_b;
            sbe_pkg::OP_DIV:   s_res = s_quo;
            sbe_pkg::OP_LT:    s_res = {31'd0, ($signed(r_a) < $signed(r_b))};
            sbe_pkg::OP_EQ:    s_res = {31'd0, (r_a == r_b)};
            sbe_pkg::OP_AND:   s_res = {31'd0, (r_a != 32'd0 && r_b != 32'd0)};
            sbe_pkg::OP_OR:    s_res = {31'd0, (r_a != 32'd0 || r_b != 32'd0)};
            sbe_pkg::OP_NOT:   s_res = {31'd0, (r_b == 32'd0)};
            default:           s_push = 1'b0;
        endcase
    end

    always_comb begin
        n_pc     = r_pc;
        n_method = r_method;
        n_halt   = r_halt;
        n_cnt    = r_cnt;
        n_frame  = r_frame;
        s_pv     = 1'b0;
        s_pval   = '0;
        if (!r_halt) begin
            if (s_st != sbe_pkg::ST_OK) begin
                n_halt = 1'b1;
            end else begin
                n_cnt = r_cnt - CW'(s_need) + CW'(s_push);
                n_pc  = s_pc_inc;
                case (s_op)
                    sbe_pkg::OP_GOTO: n_pc = r_ins.jump_target;
                    sbe_pkg::OP_IFFALSE: begin
                        if (r_b == 32'd0) begin
                            n_pc = r_ins.jump_target;
                        end
                    end
                    sbe_pkg::OP_CALL: begin
                        n_frame  = s_frame_inc;
                        n_pc     = '0;
                        n_method = r_ins.method_target;
                    end
                    sbe_pkg::OP_RETURN: begin
                        n_frame  = r_frame - FCW'(1);
                        n_pc     = r_rpc;
                        n_method = r_rm;
                    end
                    sbe_pkg::OP_PRINT: begin
                        s_pv   = 1'b1;
                        s_pval = r_b;
                    end
                    sbe_pkg::OP_STOP: n_halt = 1'b1;
                    default: ;
                endcase
            end
        end
        n_out.next_pc     = n_pc;
        n_out.method_id   = n_method;
        n_out.print_valid = s_pv;
        n_out.print_value = s_pval;
        n_out.halted      = n_halt;
        n_out.status      = r_halt ? sbe_pkg::ST_OK : s_st;
    end

    sbe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && s_ok && s_push),
        .i_waddr (SAW'(r_cnt - CW'(s_need))),
        .i_wdata (s_res),
        .i_raddr (i_cmd.load_instr ? SAW'(r_cnt - CW'(1)) : SAW'(r_cnt - CW'(2))),
        .o_rdata (s_stack_rd)
    );

    sbe_ram #(.WIDTH(32), .DEPTH(NSLOTS)) u_locals (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && s_ok && s_op == sbe_pkg::OP_STORE),
        .i_waddr (s_slot),
        .i_wdata (r_b),
        .i_raddr (s_slot),
        .o_rdata (s_local_rd)
    );

    sbe_ram #(.WIDTH(RETW), .DEPTH(FRAME_DEPTH)) u_ret (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && s_ok && s_op == sbe_pkg::OP_CALL),
        .i_waddr (FAW'(r_frame)),
        .i_wdata ({s_pc_inc, r_method}),
        .i_raddr (FAW'(r_frame - FCW'(1))),
        .o_rdata (s_ret_rd)
    );

    sbe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (s_div_done),
        .o_quotient (s_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_instr) begin
            r_ins <= i_in_item;
        end
        if (i_cmd.cap_b) begin
            r_b <= s_stack_rd;
        end
        if (i_cmd.cap_a) begin
            r_a           <= s_stack_rd;
            r_lv          <= s_local_rd;
            {r_rpc, r_rm} <= s_ret_rd;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_frame  <= '0;
            r_pc     <= '0;
            r_method <= sbe_pkg::MAIN_METHOD;
            r_halt   <= 1'b0;
            r_oval   <= 1'b0;
            for (int i = 0; i <= FRAME_DEPTH; i++) begin
                r_lw[i] <= '0;
            end
        end else begin
            if (i_cmd.commit) begin
                r_oval   <= 1'b1;
                r_cnt    <= n_cnt;
                r_frame  <= n_frame;
                r_pc     <= n_pc;
                r_method <= n_method;
                r_halt   <= n_halt;
                if (s_ok && s_op == sbe_pkg::OP_STORE) begin
                    r_lw[r_frame][s_vi] <= 1'b1;
                end
                if (s_ok && s_op == sbe_pkg::OP_CALL) begin
                    r_lw[s_frame_inc] <= '0;
                end
            end else if (!i_out_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_stat.go_div   = s_ok && (s_op == sbe_pkg::OP_DIV);
    assign o_stat.div_done = s_div_done;
    assign o_stat.out_free = !r_oval || !i_out_stall;
    assign o_out_valid     = r_oval;
    assign o_out_item      = r_out;

endmodule

FILE: rtl/core/stack_bytecode_executor.sv
// Executes one stack-machine instruction per input transfer and returns one result per
// instruction. An instruction is taken, its operands are read from the data stack, local and
// return-address memories in the RDB and RDA states, then it executes and commits; div also
// waits for the bit-serial divider. One instruction is in flight at a time; a finished result
// waits in the output register, and the next instruction may be taken meanwhile. No clearing
// pass follows reset.
module stack_bytecode_executor #(
    parameter int STACK_DEPTH = 256,
    parameter int FRAME_DEPTH = 16,
    parameter int LOCALS      = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sbe_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sbe_pkg::t_out_item o_out_item
);

    sbe_pkg::t_cmd  s_cmd;
    sbe_pkg::t_stat s_stat;

    sbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (s_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (s_cmd)
    );

    sbe_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH),
        .LOCALS      (LOCALS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/core/sbe_chk.sv
module sbe_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input sbe_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sbe_pkg::t_out_item o_out_item
);

    logic r_seen_halt;

    // set once a halted result has been transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_item.halted) begin
            r_seen_halt <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_halt |-> o_out_item.halted && !o_out_item.print_valid
            && o_out_item.status == sbe_pkg::ST_OK)
        else $error("result after halt not a plain halted echo");

    a_print_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.print_valid |-> o_out_item.print_value == 32'sd0)
        else $error("print value set without print");

endmodule

bind stack_bytecode_executor sbe_chk u_chk (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int STACK_MAX  = 256;
    localparam int FRAME_MAX  = 16;
    localparam int SLOTS      = 16;
    localparam int N_RANDOM   = 480;
    localparam int LIMIT      = 1000000;
    localparam int HOLD_LEN   = 400;
    localparam logic [sbe_pkg::OP_W-1:0] OP_UNDEF = 5'd31;

    class t_exec_scoreboard;
        logic [31:0]                  data_stack [STACK_MAX];
        int                           depth;
        logic [31:0]                  locals [(FRAME_MAX+1)*SLOTS];
        bit                           written [(FRAME_MAX+1)*SLOTS];
        logic [sbe_pkg::PC_W-1:0]     ret_pc [FRAME_MAX];
        logic [sbe_pkg::METHOD_W-1:0] ret_method [FRAME_MAX];
        int                           frames;
        logic [sbe_pkg::PC_W-1:0]     pc;
        logic [sbe_pkg::METHOD_W-1:0] method;
        bit                           halt;
        sbe_pkg::t_out_item           pending_results [$];
        int                           errors;

        function new();
            depth = 0;
            frames = 0;
            pc = '0;
            method = sbe_pkg::MAIN_METHOD;
            halt = 0;
            errors = 0;
            foreach (written[i]) written[i] = 0;
        endfunction

        function int pops(logic [sbe_pkg::OP_W-1:0] op);
            if (op >= sbe_pkg::OP_ADD && op <= sbe_pkg::OP_OR) return 2;
            if (op == sbe_pkg::OP_STORE || op == sbe_pkg::OP_NOT ||
                op == sbe_pkg::OP_IFFALSE || op == sbe_pkg::OP_PRINT) return 1;
            return 0;
        endfunction

        function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma, mb, q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void queue_result(sbe_pkg::t_out_item r);
            pending_results = {pending_results, r};
        endfunction

        // note an accepted instruction transfer and queue its expected result
        function void note(sbe_pkg::t_in_item it);
            sbe_pkg::t_out_item r;
            logic [sbe_pkg::ST_W-1:0] st;
            logic [31:0] a, b, v;
            logic [sbe_pkg::PC_W-1:0] npc;
            int need, slot;
            bit push;
            r = '0;
            a = '0;
            b = '0;
            v = '0;
            push = 0;
            st = sbe_pkg::ST_OK;
            if (halt) begin
                r.next_pc = pc;
                r.method_id = method;
                r.halted = 1'b1;
                queue_result(r);
                return;
            end
            need = pops(it.action);
            if (depth < need) st = sbe_pkg::ST_UNDERFLOW;
            else if ((it.action == sbe_pkg::OP_LOAD || it.action == sbe_pkg::OP_CONST)
                     && depth >= STACK_MAX)
                st = sbe_pkg::ST_OVERFLOW;
            else if (it.action == sbe_pkg::OP_DIV && data_stack[depth-1] == 0)
                st = sbe_pkg::ST_DIV_ZERO;
            else if (it.action == sbe_pkg::OP_CALL && frames >= FRAME_MAX)
                st = sbe_pkg::ST_FRAME_OVF;
            else if (it.action == sbe_pkg::OP_RETURN && frames == 0)
                st = sbe_pkg::ST_NO_CALLER;
            if (st != sbe_pkg::ST_OK) begin
                halt = 1;
                r.next_pc = pc;
                r.method_id = method;
                r.halted = 1'b1;
                r.status = st;
                queue_result(r);
                return;
            end
            if (need >= 1) begin
                b = data_stack[depth-1];
                depth--;
            end
            if (need >= 2) begin
                a = data_stack[depth-1];
                depth--;
            end
            npc = pc + 1'b1;
            slot = frames * SLOTS + it.var_index;
            case (it.action)
                sbe_pkg::OP_LOAD: begin
                    v = written[slot] ? locals[slot] : '0;
                    push = 1;
                end
                sbe_pkg::OP_CONST: begin
                    v = it.immediate;
                    push = 1;
                end
                sbe_pkg::OP_STORE: begin
                    locals[slot] = b;
                    written[slot] = 1;
                end
                sbe_pkg::OP_ADD: begin v = a + b; push = 1; end
                sbe_pkg::OP_SUB: begin v = a - b; push = 1; end
                sbe_pkg::OP_MUL: begin v = a * b; push = 1; end
                sbe_pkg::OP_DIV: begin v = quotient(a, b); push = 1; end
                sbe_pkg::OP_LT: begin
                    v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    push = 1;
                end
                sbe_pkg::OP_EQ: begin v = (a == b) ? 32'd1 : 32'd0; push = 1; end
                sbe_pkg::OP_AND: begin
                    v = (a != 0 && b != 0) ? 32'd1 : 32'd0;
                    push = 1;
                end
                sbe_pkg::OP_OR: begin
                    v = (a != 0 || b != 0) ? 32'd1 : 32'd0;
                    push = 1;
                end
                sbe_pkg::OP_NOT: begin v = (b == 0) ? 32'd1 : 32'd0; push = 1; end
                sbe_pkg::OP_GOTO: npc = it.jump_target;
                sbe_pkg::OP_IFFALSE: begin
                    if (b == 0) npc = it.jump_target;
                end
                sbe_pkg::OP_CALL: begin
                    ret_pc[frames] = npc;
                    ret_method[frames] = method;
                    frames++;
                    for (int i = 0; i < SLOTS; i++) written[frames*SLOTS+i] = 0;
                    npc = '0;
                    method = it.method_target;
                end
                sbe_pkg::OP_RETURN: begin
                    frames--;
                    npc = ret_pc[frames];
                    method = ret_method[frames];
                end
                sbe_pkg::OP_PRINT: begin
                    r.print_valid = 1'b1;
                    r.print_value = b;
                end
                sbe_pkg::OP_STOP: halt = 1;
                default: ;
            endcase
            if (push) begin
                data_stack[depth] = v;
                depth++;
            end
            pc = npc;
            r.next_pc = pc;
            r.method_id = method;
            r.halted = halt;
            queue_result(r);
        endfunction

        function void check(sbe_pkg::t_out_item act);
            sbe_pkg::t_out_item exp_r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, act);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (act.next_pc !== exp_r.next_pc) begin
                $display("%0t: next_pc exp %0d got %0d", $time, exp_r.next_pc, act.next_pc);
                errors++;
            end
            if (act.method_id !== exp_r.method_id) begin
                $display("%0t: method_id exp %0d got %0d", $time, exp_r.method_id,
                         act.method_id);
                errors++;
            end
            if (act.print_valid !== exp_r.print_valid) begin
                $display("%0t: print_valid exp %b got %b", $time, exp_r.print_valid,
                         act.print_valid);
                errors++;
            end
            if (act.print_value !== exp_r.print_value) begin
                $display("%0t: print_value exp %0d got %0d", $time, exp_r.print_value,
                         act.print_value);
                errors++;
            end
            if (act.halted !== exp_r.halted) begin
                $display("%0t: halted exp %b got %b", $time, exp_r.halted, act.halted);
                errors++;
            end
            if (act.status !== exp_r.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp_r.status, act.status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    sbe_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    sbe_pkg::t_out_item o_out_item;

    t_exec_scoreboard sb;
    int cycles = 0;
    int results_seen = 0;
    int burst_left;

    stack_bytecode_executor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check(o_out_item);
            results_seen <= results_seen + 1;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int mode, len;
        bit held;
        held = 0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(20, 200);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= 1'($urandom_range(0, 1));
                    default: i_out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
            if (!held && results_seen >= 100) begin
                held = 1;
                @(posedge i_clk);
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
        end
    end

    function automatic sbe_pkg::t_in_item mk(logic [sbe_pkg::OP_W-1:0] op, logic [31:0] imm,
                                             logic [3:0] vi, logic [sbe_pkg::PC_W-1:0] jt,
                                             logic [sbe_pkg::METHOD_W-1:0] mt);
        sbe_pkg::t_in_item it;
        it.action = op;
        it.immediate = imm;
        it.var_index = vi;
        it.jump_target = jt;
        it.method_target = mt;
        return it;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // instruction that keeps the machine running
    function automatic sbe_pkg::t_in_item pick_running();
        sbe_pkg::t_in_item it;
        bit ok;
        ok = 0;
        while (!ok) begin
            it = mk(5'($urandom_range(0, 19)), rand_value(), 4'($urandom), 10'($urandom),
                    4'($urandom));
            if (it.action >= 18) it.action = 5'($urandom_range(18, 31));
            if (it.action == sbe_pkg::OP_STOP) continue;
            if (sb.depth < sb.pops(it.action)) continue;
            if ((it.action == sbe_pkg::OP_LOAD || it.action == sbe_pkg::OP_CONST)
                && sb.depth >= 200) continue;
            if (it.action == sbe_pkg::OP_DIV && sb.data_stack[sb.depth-1] == 0) continue;
            if (it.action == sbe_pkg::OP_CALL
                && (sb.frames >= FRAME_MAX || $urandom_range(0, 2) == 0))
                continue;
            if (it.action == sbe_pkg::OP_RETURN && sb.frames == 0) continue;
            ok = 1;
        end
        return it;
    endfunction

    task automatic send(sbe_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 25);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note(it);
        burst_left--;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        burst_left = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every operation but stop, wrap cases
        send(mk(sbe_pkg::OP_CONST, 32'h8000_0000, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_CONST, 32'hffff_ffff, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_DIV, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_PRINT, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_CONST, 32'h7fff_ffff, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_CONST, 32'd1, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_ADD, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_CONST, -32'sd3, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_MUL, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_CONST, 32'd5, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_LT, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_CONST, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_EQ, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_CONST, 32'd9, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_AND, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_CONST, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_OR, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_NOT, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_LOAD, 32'd0, 4'd3, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_STORE, 32'd0, 4'd3, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_CALL, 32'd0, 4'd0, 10'd0, 4'hf));
        send(mk(sbe_pkg::OP_LOAD, 32'd0, 4'd3, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_RETURN, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_IFFALSE, 32'd0, 4'd0, 10'd512, 4'd0));
        send(mk(sbe_pkg::OP_GOTO, 32'd0, 4'd0, 10'h3ff, 4'd0));
        send(mk(OP_UNDEF, 32'hffff_ffff, 4'hf, 10'h3ff, 4'hf));
        send(mk(sbe_pkg::OP_LOAD, 32'd0, 4'd15, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_SUB, 32'd0, 4'd0, 10'd0, 4'd0));
        send(mk(sbe_pkg::OP_PRINT, 32'd0, 4'd0, 10'd0, 4'd0));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) wait_drained();
            send(pick_running());
        end

        // drive the machine into one halting condition, then run past it
        case ($urandom_range(0, 4))
            0: send(mk(sbe_pkg::OP_STOP, 32'd0, 4'd0, 10'd0, 4'd0));
            1: begin
                send(mk(sbe_pkg::OP_CONST, 32'd7, 4'd0, 10'd0, 4'd0));
                send(mk(sbe_pkg::OP_CONST, 32'd0, 4'd0, 10'd0, 4'd0));
                send(mk(sbe_pkg::OP_DIV, 32'd0, 4'd0, 10'd0, 4'd0));
            end
            2: begin
                while (sb.frames > 0)
                    send(mk(sbe_pkg::OP_RETURN, 32'd0, 4'd0, 10'd0, 4'd0));
                send(mk(sbe_pkg::OP_RETURN, 32'd0, 4'd0, 10'd0, 4'd0));
            end
            3: begin
                while (sb.frames < FRAME_MAX)
                    send(mk(sbe_pkg::OP_CALL, 32'd0, 4'd0, 10'd0, 4'($urandom)));
                send(mk(sbe_pkg::OP_CALL, 32'd0, 4'd0, 10'd0, 4'($urandom)));
            end
            default: begin
                while (sb.depth > 0)
                    send(mk(sbe_pkg::OP_PRINT, 32'd0, 4'd0, 10'd0, 4'd0));
                send(mk(sbe_pkg::OP_PRINT, 32'd0, 4'd0, 10'd0, 4'd0));
            end
        endcase
        repeat (6) send(mk(5'($urandom_range(0, 17)), $urandom, 4'($urandom), 10'($urandom),
                           4'($urandom)));

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
